// File: rtl/rrq_pkg.sv
// Shared constants and beat types for the random-remove queue.
package rrq_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int RAND_W     = 15;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int STEP_W     = $clog2(RAND_W);
  localparam int STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [ITEM_WIDTH-1:0] item_in;
    logic [RAND_W-1:0]     rand_value;
  } in_beat_t;

  typedef struct packed {
    logic [ITEM_WIDTH-1:0] item_out;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      count_after;
  } out_beat_t;

endpackage

// File: rtl/random_remove_queue.sv
// Random-remove queue: enqueue and failed requests answer the cycle after the accepting beat.
// A successful dequeue answers once its random value is reduced one remainder bit per
// cycle, then the slot read, the last-item read and the write-back on the single RAM port pair.
// One request is in flight at a time; busy is high while a dequeue is reduced, read and
// written back; enqueues can follow every cycle while it is low. The receiver cannot stall.
// Synchronous active-low reset empties the store; slot contents are not cleared.
module random_remove_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output rrq_pkg::out_beat_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MOD     = 5'b00010,
    S_RD_PICK = 5'b00100,
    S_RD_LAST = 5'b01000,
    S_WR      = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rrq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rrq_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [rrq_pkg::RAND_W-1:0]   div_r, div_nxt;
  logic [rrq_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [rrq_pkg::ITEM_WIDTH-1:0] pick_item_r, pick_item_nxt;
  logic                         out_valid_r, out_valid_nxt;
  rrq_pkg::out_beat_t           out_r, out_nxt;

  logic                         accept;
  logic [rrq_pkg::CNT_W:0]      trial;
  logic [rrq_pkg::CNT_W:0]      count_ext;
  logic [rrq_pkg::CNT_W-1:0]    last_cnt;
  logic                         ram_we;
  logic [rrq_pkg::ADDR_W-1:0]   ram_waddr;
  logic [rrq_pkg::ITEM_WIDTH-1:0] ram_wdata;
  logic [rrq_pkg::ADDR_W-1:0]   ram_raddr;
  logic [rrq_pkg::ITEM_WIDTH-1:0] ram_rdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign count_ext = {1'b0, count_r};
  assign trial     = {rem_r, div_r[rrq_pkg::RAND_W-1]};
  assign last_cnt  = count_r - rrq_pkg::CNT_W'(1);

  rrq_ram #(
    .WIDTH(rrq_pkg::ITEM_WIDTH),
    .DEPTH(rrq_pkg::DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    pick_item_nxt = pick_item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[rrq_pkg::ADDR_W-1:0];
    ram_wdata     = in_data.item_in;
    ram_raddr     = rem_r[rrq_pkg::ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.item_out = '0;
          out_nxt.status   = rrq_pkg::ST_OK;
          if (in_data.req_type == rrq_pkg::REQ_ENQ) begin
            out_valid_nxt = 1'b1;
            if (count_r >= rrq_pkg::CNT_W'(rrq_pkg::DEPTH)) begin
              out_nxt.status = rrq_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + rrq_pkg::CNT_W'(1);
            end
            out_nxt.count_after = count_nxt;
          end else if (count_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_nxt.status      = rrq_pkg::ST_EMPTY;
            out_nxt.count_after = count_r;
          end else begin
            rem_nxt   = '0;
            div_nxt   = in_data.rand_value;
            step_nxt  = rrq_pkg::STEP_W'(rrq_pkg::RAND_W - 1);
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        // Restoring remainder: one dividend bit per cycle, MSB first.
        if (trial >= count_ext) begin
          rem_nxt = rrq_pkg::CNT_W'(trial - count_ext);
        end else begin
          rem_nxt = rrq_pkg::CNT_W'(trial);
        end
        div_nxt  = {div_r[rrq_pkg::RAND_W-2:0], 1'b0};
        step_nxt = step_r - rrq_pkg::STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_RD_PICK;
        end
      end
      S_RD_PICK: begin
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        ram_raddr     = last_cnt[rrq_pkg::ADDR_W-1:0];
        pick_item_nxt = ram_rdata;
        state_nxt     = S_WR;
      end
      S_WR: begin
        // The last item fills the vacated slot; harmless when they coincide.
        ram_we              = 1'b1;
        ram_waddr           = rem_r[rrq_pkg::ADDR_W-1:0];
        ram_wdata           = ram_rdata;
        count_nxt           = last_cnt;
        out_valid_nxt       = 1'b1;
        out_nxt.item_out    = pick_item_r;
        out_nxt.status      = rrq_pkg::ST_OK;
        out_nxt.count_after = last_cnt;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    pick_item_r <= pick_item_nxt;
    out_r       <= out_nxt;
  end

  a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (rem_r < count_r))
    else $error("remainder not below count during reduction");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rrq_pkg::CNT_W'(rrq_pkg::DEPTH))
    else $error("item count exceeds depth");

  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WR || accept))
    else $error("slot write outside accept or write-back");

  a_busy_from_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && $past(state_r) == S_IDLE) |->
      ($past(start) && $past(in_data.req_type) == rrq_pkg::REQ_DEQ))
    else $error("reduction started without a dequeue beat");

  a_wr_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (out_valid && out_data.status == rrq_pkg::ST_OK))
    else $error("write-back not followed by a result");

endmodule

// File: rtl/rrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/random_remove_queue_tb.sv
// Self-checking testbench for the random-remove queue, with its scoreboard class.
`timescale 1ns / 100ps

class rrq_scoreboard;
  bit [rrq_pkg::ITEM_WIDTH-1:0] shadow_slots [rrq_pkg::DEPTH];
  int                           shadow_level;
  rrq_pkg::out_beat_t           expected_replies [$];
  int                           mismatches;
  int                           replies_seen;
  int                           enq_ok;
  int                           deq_ok;
  int                           full_drops;
  int                           empty_deqs;

  function new();
    shadow_level = 0;
    mismatches   = 0;
    replies_seen = 0;
    enq_ok       = 0;
    deq_ok       = 0;
    full_drops   = 0;
    empty_deqs   = 0;
  endfunction

  // Works out the reply for an accepted request and updates the shadow store.
  function void note_request(rrq_pkg::in_beat_t req);
    rrq_pkg::out_beat_t reply;
    int unsigned        pick;
    reply = '0;
    if (req.req_type == rrq_pkg::REQ_ENQ) begin
      if (shadow_level >= rrq_pkg::DEPTH) begin
        reply.status = rrq_pkg::ST_FULL;
        full_drops++;
      end else begin
        shadow_slots[shadow_level] = req.item_in;
        shadow_level++;
        reply.status = rrq_pkg::ST_OK;
        enq_ok++;
      end
    end else begin
      if (shadow_level == 0) begin
        reply.status = rrq_pkg::ST_EMPTY;
        empty_deqs++;
      end else begin
        pick = int'(req.rand_value) % shadow_level;
        reply.item_out = shadow_slots[pick];
        shadow_slots[pick] = shadow_slots[shadow_level - 1];
        shadow_level--;
        reply.status = rrq_pkg::ST_OK;
        deq_ok++;
      end
    end
    reply.count_after = rrq_pkg::CNT_W'(shadow_level);
    expected_replies.push_back(reply);
  endfunction

  function void check_response(rrq_pkg::out_beat_t got);
    rrq_pkg::out_beat_t want;
    replies_seen++;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: reply beat with no request pending: item %h status %0d count %0d",
                 got.item_out, got.status, got.count_after);
      return;
    end
    want = expected_replies.pop_front();
    if (got.item_out !== want.item_out || got.status !== want.status ||
        got.count_after !== want.count_after) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: reply %0d mismatch: item %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                 replies_seen, want.item_out, got.item_out, want.status, got.status,
                 want.count_after, got.count_after);
    end
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction
endclass

module random_remove_queue_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  rrq_pkg::in_beat_t  in_data = '0;
  logic               busy;
  logic               out_valid;
  rrq_pkg::out_beat_t out_data;

  rrq_scoreboard sb;
  int            cycles   = 0;
  bit            no_pause = 1'b0;

  random_remove_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_response(out_data);
  end

  // Presents one request beat and returns at the edge that accepts it.
  task automatic issue(input logic req, input logic [rrq_pkg::ITEM_WIDTH-1:0] item,
                       input logic [rrq_pkg::RAND_W-1:0] rnd);
    rrq_pkg::in_beat_t beat;
    beat.req_type   = req;
    beat.item_in    = item;
    beat.rand_value = rnd;
    in_data <= beat;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(beat);
    maybe_pause();
  endtask

  // Occasional gap on the request side; long gaps land in the middle of a dequeue.
  task automatic maybe_pause();
    int gap;
    if (!no_pause && $urandom_range(99) < 23) begin
      gap = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    issue(rrq_pkg::REQ_DEQ, 32'hFFFF_FFFF, 15'h7FFF);
    issue(rrq_pkg::REQ_DEQ, 32'h0, 15'h0);
    issue(rrq_pkg::REQ_ENQ, 32'h0, 15'h7FFF);
    issue(rrq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 15'h0);
    for (int i = 0; i < rrq_pkg::DEPTH - 2; i++)
      issue(rrq_pkg::REQ_ENQ, $urandom, rrq_pkg::RAND_W'($urandom));
    // The store is full here, so this one must be dropped.
    issue(rrq_pkg::REQ_ENQ, 32'hA5A5_5A5A, 15'h7FFF);
    issue(rrq_pkg::REQ_DEQ, 32'hFFFF_FFFF, 15'h7FFF);
    issue(rrq_pkg::REQ_DEQ, 32'h0, 15'h0);
    issue(rrq_pkg::REQ_ENQ, 32'h1234_5678, 15'h0);
    issue(rrq_pkg::REQ_ENQ, 32'h8765_4321, 15'h0);
    issue(rrq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 15'h0);
  endtask

  // Phases with a biased request mix, so the store swings between full and empty.
  task automatic run_random(input int n_items);
    int                             enq_bias;
    logic                           req;
    logic [rrq_pkg::ITEM_WIDTH-1:0] item;
    logic [rrq_pkg::RAND_W-1:0]     rnd;
    enq_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_bias = 15;
          1: enq_bias = 50;
          default: enq_bias = 85;
        endcase
      end
      no_pause = (i >= 600 && i < 900);
      req = ($urandom_range(99) < enq_bias) ? rrq_pkg::REQ_ENQ : rrq_pkg::REQ_DEQ;
      case ($urandom_range(9))
        0: item = '0;
        1: item = '1;
        default: item = $urandom;
      endcase
      case ($urandom_range(9))
        0: rnd = '0;
        1: rnd = '1;
        2: rnd = rrq_pkg::RAND_W'($urandom_range(31));
        default: rnd = rrq_pkg::RAND_W'($urandom_range(32767));
      endcase
      issue(req, item, rnd);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(1800);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    $display("tb: %0d enqueues stored, %0d dequeues served, %0d full drops, %0d empty dequeues",
             sb.enq_ok, sb.deq_ok, sb.full_drops, sb.empty_deqs);
    $display("tb: %0d reply beats checked, %0d mismatches", sb.replies_seen, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// File: files.f
rtl/rrq_pkg.sv
rtl/rrq_ram.sv
rtl/random_remove_queue.sv
bench/random_remove_queue_tb.sv
